// ----- hw/rtl/tbg_pkg.sv -----
// ----------------------------------------------------------------------------
// tbg_pkg: shared types and constants of the two-body gravity block
// Widths of the position, separation and divider datapaths, the register
// indexes of the configuration port and the structs passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package tbg_pkg;

	// Position and acceleration formats.
	localparam int POS_W     = 32;
	localparam int FRAC      = 16;
	localparam int ACC_W     = 32;
	localparam int MASS_FRAC = 16;
	localparam int M_W       = MASS_FRAC + 1;

	// Datapath widths derived from the position format.
	localparam int MAG_W  = POS_W;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int RHO_W  = (SUM_W + 1) / 2;
	localparam int TR_W   = SUM_W + 1;
	localparam int Q_W    = RHO_W;
	localparam int NUM_W  = Q_W + FRAC;
	localparam int CMP_W  = RHO_W + Q_W;
	localparam int U_W    = FRAC + 1;

	// Pipeline depth: three input stages, square root, capture stage,
	// three divisions and one product stage, and the final saturation stage.
	localparam int SQRT_LAT = RHO_W;
	localparam int DIV_LAT  = Q_W;
	localparam int PIPE_LAT = 3 + SQRT_LAT + 1 + DIV_LAT + 1 + 2 * DIV_LAT + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;
	localparam int MF_W       = 17;
	localparam int CAP_W      = 31;
	localparam logic [MF_W-1:0]  MF_RESET  = MF_W'(32768);
	localparam logic [CAP_W-1:0] CAP_RESET = '0;
	localparam logic [M_W-1:0]   MASS_ONE  = M_W'(1) << MASS_FRAC;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASS_FRACTION  = 1'b0,
		REG_CAPTURE_RADIUS = 1'b1
	} cfg_reg_t;

	// Output lanes: body one x and y, body two x and y.
	localparam int LANES   = 4;
	localparam int LANE_1X = 0;
	localparam int LANE_1Y = 1;
	localparam int LANE_2X = 2;
	localparam int LANE_2Y = 3;

	// Separation magnitudes and signs carried alongside the square root.
	typedef struct packed {
		logic [MAG_W-1:0] dx;
		logic [MAG_W-1:0] dy;
		logic             nx;
		logic             ny;
	} pre_t;

	// Per-item control carried alongside the divisions.
	typedef struct packed {
		logic             captured;
		logic [LANES-1:0] neg;
		logic [M_W-1:0]   m1;
		logic [M_W-1:0]   m2;
		logic [RHO_W-1:0] rho;
	} ctl_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] first_accel_x;
		logic signed [ACC_W-1:0] first_accel_y;
		logic signed [ACC_W-1:0] second_accel_x;
		logic signed [ACC_W-1:0] second_accel_y;
		logic                    captured;
	} res_t;

	// Signs a quotient magnitude and saturates it to the output format.
	function automatic logic [ACC_W-1:0] sat_signed(
		input logic [Q_W-1:0] mag, input logic ovf, input logic neg);
		logic [Q_W-1:0] lim_pos;
		logic [Q_W-1:0] lim_neg;
		logic [ACC_W-1:0] res;
		lim_pos = (Q_W'(1) << (ACC_W - 1)) - Q_W'(1);
		lim_neg = Q_W'(1) << (ACC_W - 1);
		if (neg) begin
			if (ovf || mag > lim_neg) res = ACC_W'(1) << (ACC_W - 1);
			else res = ACC_W'(-mag);
		end else begin
			if (ovf || mag > lim_pos) res = ACC_W'(lim_pos);
			else res = ACC_W'(mag);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tbg_pos_if.sv -----
// ----------------------------------------------------------------------------
// tbg_pos_if: input channel of the two-body gravity block
// Valid/ready channel that moves one item of two planar positions.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbg_pos_if import tbg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] first_x;
	logic signed [POS_W-1:0] first_y;
	logic signed [POS_W-1:0] second_x;
	logic signed [POS_W-1:0] second_y;

	modport source(output valid, first_x, first_y, second_x, second_y, input ready);
	modport sink(input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tbg_acc_if.sv -----
// ----------------------------------------------------------------------------
// tbg_acc_if: output channel of the two-body gravity block
// Valid/ready channel that moves one item of four accelerations and a flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbg_acc_if import tbg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] first_accel_x;
	logic signed [ACC_W-1:0] first_accel_y;
	logic signed [ACC_W-1:0] second_accel_x;
	logic signed [ACC_W-1:0] second_accel_y;
	logic                    captured;

	modport source(output valid, first_accel_x, first_accel_y, second_accel_x,
		second_accel_y, captured, input ready);
	modport sink(input valid, first_accel_x, first_accel_y, second_accel_x,
		second_accel_y, captured, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/two_body_gravity_derivative.sv -----
// ----------------------------------------------------------------------------
// two_body_gravity_derivative: planar two-body gravitational acceleration
// The block accepts one item per clock while it is not stalled and returns one
// result item for each, in order. The latency is set by the
// square root (one bit per stage, 33 stages) and the three divider chains
// (33 stages each) that produce |d|/rho, m*u/rho and v/rho. The pipeline
// stalls as a whole only when both the output register and the skid entry
// behind it hold items; one more item is taken while a result waits.
// Configuration is taken at any time but is meant to change only while no
// item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module two_body_gravity_derivative import tbg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tbg_pos_if.sink               pos,
	tbg_acc_if.source             acc
);

	logic [MF_W-1:0]  mf_q;
	logic [CAP_W-1:0] cap_q;
	logic             en;

	logic [PIPE_LAT-1:0] vld_s;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mf_q  <= MF_RESET;
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_MASS_FRACTION:  mf_q  <= MF_W'(cfg_data);
				REG_CAPTURE_RADIUS: cap_q <= CAP_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= {vld_s[PIPE_LAT-2:0], pos.valid};
	end

	// Stage 1: signed differences reduced to magnitude and sign.
	logic [POS_W:0] dxs, dys;
	pre_t           pre_s1;

	assign dxs = {pos.first_x[POS_W-1], pos.first_x} - {pos.second_x[POS_W-1], pos.second_x};
	assign dys = {pos.first_y[POS_W-1], pos.first_y} - {pos.second_y[POS_W-1], pos.second_y};

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1.nx <= dxs[POS_W];
			pre_s1.ny <= dys[POS_W];
			pre_s1.dx <= MAG_W'(dxs[POS_W] ? -dxs : dxs);
			pre_s1.dy <= MAG_W'(dys[POS_W] ? -dys : dys);
		end
	end

	// Stage 2: squares. Stage 3: their sum.
	logic [SQ_W-1:0]  sqx_s2, sqy_s2;
	logic [SUM_W-1:0] sum_s3;
	pre_t             pre_s2, pre_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= pre_s1.dx * pre_s1.dx;
			sqy_s2 <= pre_s1.dy * pre_s1.dy;
			pre_s2 <= pre_s1;
			sum_s3 <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2);
			pre_s3 <= pre_s2;
		end
	end

	// Separation.
	logic [RHO_W-1:0] rho;
	pre_t             pre_r;

	tbg_sqrt u_sqrt (
		.clk     (clk),
		.en      (en),
		.sum     (sum_s3),
		.pre_in  (pre_s3),
		.rho     (rho),
		.pre_out (pre_r)
	);

	// Stage 4: capture test, masses and signs of the four lanes.
	ctl_t             ctl_s4;
	logic [MAG_W-1:0] dx_s4, dy_s4;
	logic [M_W-1:0]   m1;

	assign m1 = (mf_q > MF_W'(MASS_ONE)) ? MASS_ONE : M_W'(mf_q);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4.captured     <= (rho == '0) || (rho < RHO_W'(cap_q));
			ctl_s4.neg[LANE_1X] <= !pre_r.nx && (pre_r.dx != '0);
			ctl_s4.neg[LANE_1Y] <= !pre_r.ny && (pre_r.dy != '0);
			ctl_s4.neg[LANE_2X] <= pre_r.nx;
			ctl_s4.neg[LANE_2Y] <= pre_r.ny;
			ctl_s4.m1           <= m1;
			ctl_s4.m2           <= MASS_ONE - m1;
			ctl_s4.rho          <= rho;
			dx_s4               <= pre_r.dx;
			dy_s4               <= pre_r.dy;
		end
	end

	// Unit vector components u = |d| * 2^FRAC / rho.
	logic [Q_W-1:0] ux, uy;
	logic           ovf_ux, ovf_uy;

	tbg_div u_div_ux (
		.clk (clk), .en (en),
		.num (NUM_W'({dx_s4, FRAC'(0)})), .den (ctl_s4.rho),
		.quo (ux), .ovf (ovf_ux)
	);

	tbg_div u_div_uy (
		.clk (clk), .en (en),
		.num (NUM_W'({dy_s4, FRAC'(0)})), .den (ctl_s4.rho),
		.quo (uy), .ovf (ovf_uy)
	);

	// Control delay lines beside the three divider chains.
	ctl_t ctl_u_s [DIV_LAT];
	ctl_t ctl_v_s [DIV_LAT];
	ctl_t ctl_a_s [DIV_LAT];
	ctl_t ctl_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_u_s[0] <= ctl_s4;
			ctl_v_s[0] <= ctl_s5;
			ctl_a_s[0] <= ctl_v_s[DIV_LAT-1];
			for (int i = 1; i < DIV_LAT; i++) begin
				ctl_u_s[i] <= ctl_u_s[i-1];
				ctl_v_s[i] <= ctl_v_s[i-1];
				ctl_a_s[i] <= ctl_a_s[i-1];
			end
		end
	end

	// Stage 5: apply the other body's mass in Q1.16.
	logic [U_W-1:0]     um_s5 [LANES];
	logic [U_W-1:0]     u_lane [LANES];
	logic [M_W-1:0]     m_lane [LANES];
	logic [U_W+M_W-1:0] prod [LANES];

	assign u_lane[LANE_1X] = U_W'(ux);
	assign u_lane[LANE_1Y] = U_W'(uy);
	assign u_lane[LANE_2X] = U_W'(ux);
	assign u_lane[LANE_2Y] = U_W'(uy);
	assign m_lane[LANE_1X] = ctl_u_s[DIV_LAT-1].m2;
	assign m_lane[LANE_1Y] = ctl_u_s[DIV_LAT-1].m2;
	assign m_lane[LANE_2X] = ctl_u_s[DIV_LAT-1].m1;
	assign m_lane[LANE_2Y] = ctl_u_s[DIV_LAT-1].m1;

	for (genvar j = 0; j < LANES; j++) begin : g_mul
		assign prod[j] = u_lane[j] * m_lane[j];
		always_ff @(posedge clk) begin
			if (en) um_s5[j] <= U_W'(prod[j] >> MASS_FRAC);
		end
	end

	always_ff @(posedge clk) begin
		if (en) ctl_s5 <= ctl_u_s[DIV_LAT-1];
	end

	// v = um * 2^FRAC / rho, then a = v * 2^FRAC / rho, per lane.
	logic [Q_W-1:0] qv [LANES];
	logic [Q_W-1:0] qa [LANES];
	logic           ovf_v [LANES];
	logic           ovf_a [LANES];

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		tbg_div u_div_v (
			.clk (clk), .en (en),
			.num (NUM_W'({um_s5[j], FRAC'(0)})), .den (ctl_s5.rho),
			.quo (qv[j]), .ovf (ovf_v[j])
		);
		tbg_div u_div_a (
			.clk (clk), .en (en),
			.num ({qv[j], FRAC'(0)}), .den (ctl_v_s[DIV_LAT-1].rho),
			.quo (qa[j]), .ovf (ovf_a[j])
		);
	end

	// Stage 6: sign, saturate and zero on capture.
	res_t res_s6;
	ctl_t ctl_f;

	assign ctl_f = ctl_a_s[DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6.captured <= ctl_f.captured;
			if (ctl_f.captured) begin
				res_s6.first_accel_x  <= '0;
				res_s6.first_accel_y  <= '0;
				res_s6.second_accel_x <= '0;
				res_s6.second_accel_y <= '0;
			end else begin
				res_s6.first_accel_x  <= sat_signed(qa[LANE_1X], ovf_a[LANE_1X],
					ctl_f.neg[LANE_1X]);
				res_s6.first_accel_y  <= sat_signed(qa[LANE_1Y], ovf_a[LANE_1Y],
					ctl_f.neg[LANE_1Y]);
				res_s6.second_accel_x <= sat_signed(qa[LANE_2X], ovf_a[LANE_2X],
					ctl_f.neg[LANE_2X]);
				res_s6.second_accel_y <= sat_signed(qa[LANE_2Y], ovf_a[LANE_2Y],
					ctl_f.neg[LANE_2Y]);
			end
		end
	end

	// Output register with one skid entry behind it.
	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	assign en        = !skid_valid_q;
	assign pos.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!skid_valid_q) begin
			if (!out_valid_q || acc.ready) out_valid_q <= vld_s[PIPE_LAT-1];
			else if (vld_s[PIPE_LAT-1]) skid_valid_q <= 1'b1;
		end else if (acc.ready) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			if (!out_valid_q || acc.ready) out_q <= res_s6;
			else skid_q <= res_s6;
		end else if (acc.ready) begin
			out_q <= skid_q;
		end
	end

	assign acc.valid          = out_valid_q;
	assign acc.first_accel_x  = out_q.first_accel_x;
	assign acc.first_accel_y  = out_q.first_accel_y;
	assign acc.second_accel_x = out_q.second_accel_x;
	assign acc.second_accel_y = out_q.second_accel_y;
	assign acc.captured       = out_q.captured;

	// The skid entry is only ever occupied behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds an item while the output register is empty");

	// The skid entry fills only when the output was stalled.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !acc.ready))
		else $error("skid entry filled without an output stall");

	// A captured result carries zero accelerations.
	a_capture_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(acc.valid && acc.captured) |-> (acc.first_accel_x == '0 &&
		acc.first_accel_y == '0 && acc.second_accel_x == '0 &&
		acc.second_accel_y == '0))
		else $error("captured result with nonzero acceleration");

endmodule

`default_nettype wire

// ----- hw/rtl/tbg_sqrt.sv -----
// ----------------------------------------------------------------------------
// tbg_sqrt: pipelined integer square root
// One result bit per register stage; the separation magnitudes and signs
// travel beside the partial root.
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_sqrt import tbg_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SUM_W-1:0] sum,
	input  pre_t             pre_in,
	output logic [RHO_W-1:0] rho,
	output pre_t             pre_out
);

	logic [SUM_W-1:0] rem_s  [1:SQRT_LAT];
	logic [RHO_W-1:0] root_s [1:SQRT_LAT];
	pre_t             pre_s  [1:SQRT_LAT];

	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
		localparam int B = RHO_W - 1 - k;
		logic [SUM_W-1:0] cur_rem;
		logic [RHO_W-1:0] cur_root;
		pre_t             cur_pre;
		logic [TR_W-1:0]  trial;
		logic             take;

		if (k == 0) begin : g_first
			assign cur_rem  = sum;
			assign cur_root = '0;
			assign cur_pre  = pre_in;
		end else begin : g_next
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_pre  = pre_s[k];
		end

		// Setting bit B grows the square by root*2^(B+1) + 2^(2B).
		assign trial = (TR_W'(cur_root) << (B + 1)) | (TR_W'(1) << (2 * B));
		assign take  = TR_W'(cur_rem) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? SUM_W'(TR_W'(cur_rem) - trial) : cur_rem;
				root_s[k+1] <= cur_root | (RHO_W'(take) << B);
				pre_s[k+1]  <= cur_pre;
			end
		end
	end

	assign rho     = root_s[SQRT_LAT];
	assign pre_out = pre_s[SQRT_LAT];

endmodule

`default_nettype wire

// ----- hw/rtl/tbg_div.sv -----
// ----------------------------------------------------------------------------
// tbg_div: pipelined restoring divider
// One quotient bit per register stage. Quotients that do not fit the
// quotient width raise ovf, which is known from the first stage on.
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_div import tbg_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [RHO_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);

	logic [NUM_W-1:0] rem_s [1:DIV_LAT];
	logic [RHO_W-1:0] den_s [1:DIV_LAT];
	logic [Q_W-1:0]   q_s   [1:DIV_LAT];
	logic             ovf_s [1:DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		localparam int B = Q_W - 1 - k;
		logic [NUM_W-1:0] cur_rem;
		logic [RHO_W-1:0] cur_den;
		logic [Q_W-1:0]   cur_q;
		logic             cur_ovf;
		logic [CMP_W-1:0] shd;
		logic [CMP_W-1:0] remx;
		logic             take;

		if (k == 0) begin : g_first
			assign cur_rem = num;
			assign cur_den = den;
			assign cur_q   = '0;
			assign cur_ovf = CMP_W'(num >> Q_W) >= CMP_W'(den);
		end else begin : g_next
			assign cur_rem = rem_s[k];
			assign cur_den = den_s[k];
			assign cur_q   = q_s[k];
			assign cur_ovf = ovf_s[k];
		end

		// Subtract the shifted divisor where it fits.
		assign shd  = CMP_W'(cur_den) << B;
		assign remx = CMP_W'(cur_rem);
		assign take = remx >= shd;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? NUM_W'(remx - shd) : cur_rem;
				den_s[k+1] <= cur_den;
				q_s[k+1]   <= cur_q | (Q_W'(take) << B);
				ovf_s[k+1] <= cur_ovf;
			end
		end
	end

	assign quo = q_s[DIV_LAT];
	assign ovf = ovf_s[DIV_LAT];

endmodule

`default_nettype wire
